/* design/obb_overlap_test_2d_top_defines.svh */
// Assertion macros used by the checker file.
`ifndef OBB_OVERLAP_TEST_2D_TOP_DEFINES_SVH
`define OBB_OVERLAP_TEST_2D_TOP_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define OBB_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("%m: label failed");

// Consequence a fixed number of cycles after the antecedent.
`define OBB_ASSERT_DELAY(label, clk, rst_n, ante, dly, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> ##(dly) (cons)) \
        else $error("%m: label failed");

// Next-cycle implication, checked during reset as well.
`define OBB_ASSERT_NEXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("%m: label failed");

`endif

/* design/obb_pkg.sv */
// Package: widths, fixed-point shifts, axis codes and beat types of the OBB overlap test.
`default_nettype none
package obb_pkg;

    localparam int COORD_W    = 24;              // Q15.8 coordinate width
    localparam int HALF_W     = COORD_W - 1;     // unsigned half-length width
    localparam int ROT_W      = 16;              // Q1.14 rotation term width
    localparam int AXIS_W     = 3;
    localparam int DIST_SHIFT = 14;              // Q.22 -> Q.36
    localparam int OWN_SHIFT  = 28;              // Q.8  -> Q.36
    localparam int PIPE_DEPTH = 6;               // accept edge to result edge

    localparam logic [AXIS_W-1:0] AXIS_AX   = 3'd0;
    localparam logic [AXIS_W-1:0] AXIS_AY   = 3'd1;
    localparam logic [AXIS_W-1:0] AXIS_BX   = 3'd2;
    localparam logic [AXIS_W-1:0] AXIS_BY   = 3'd3;
    localparam logic [AXIS_W-1:0] AXIS_NONE = 3'd4;

    typedef struct packed {
        logic signed [COORD_W-1:0] a_center_x;
        logic signed [COORD_W-1:0] a_center_y;
        logic signed [ROT_W-1:0]   a_cos;
        logic signed [ROT_W-1:0]   a_sin;
        logic        [HALF_W-1:0]  a_half_x;
        logic        [HALF_W-1:0]  a_half_y;
        logic signed [COORD_W-1:0] b_center_x;
        logic signed [COORD_W-1:0] b_center_y;
        logic signed [ROT_W-1:0]   b_cos;
        logic signed [ROT_W-1:0]   b_sin;
        logic        [HALF_W-1:0]  b_half_x;
        logic        [HALF_W-1:0]  b_half_y;
    } t_obb_in;

    typedef struct packed {
        logic              overlap;
        logic [AXIS_W-1:0] separating_axis;
    } t_obb_out;

endpackage
`default_nettype wire

/* design/obb_overlap_test_2d_top.sv */
// Top level: six-stage pipelined separating-axis overlap test for two planar oriented boxes.
//
//  channel   signals                      direction  flow
//  -------   --------------------------   ---------  --------------------------------
//  command   i_start, o_busy, i_item      in         beat taken when i_start && !o_busy
//  result    o_done, o_result             out        one-cycle strobe, no back-pressure
//
// One beat per clock while o_busy is low. The pipe is set by the two multiply
// levels (distance/rotation products, then radius products), each followed by
// an adder level, then the compare. o_busy is high during reset and for the
// first cycle after it; reset drops every beat in flight.
`default_nettype none
module obb_overlap_test_2d_top (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_start,
    output logic                    o_busy,
    input  wire  obb_pkg::t_obb_in  i_item,
    output logic                    o_done,
    output obb_pkg::t_obb_out       o_result
);

    localparam int CW   = obb_pkg::COORD_W;
    localparam int HW   = obb_pkg::HALF_W;
    localparam int RTW  = obb_pkg::ROT_W;
    localparam int DW   = CW + 1;             // centre difference
    localparam int PDW  = DW + RTW;           // distance product
    localparam int DOTW = PDW + 1;            // distance dot product, signed
    localparam int MAGW = DOTW - 1;           // its magnitude
    localparam int PRW  = 2 * RTW;            // rotation product
    localparam int CRW  = PRW + 1;            // rotation dot product, signed
    localparam int CMW  = CRW - 1;            // its magnitude
    localparam int XW   = CMW + HW;           // radius cross term
    localparam int RW   = XW + 2;             // summed radius
    localparam int DSH  = obb_pkg::DIST_SHIFT;
    localparam int OSH  = obb_pkg::OWN_SHIFT;

    // run flag: low in reset, high after
    logic r_run;

    // stage 1: centre difference, operands
    logic                  r1_vld;
    logic signed [DW-1:0]  r1_dx, r1_dy;
    logic signed [RTW-1:0] r1_ac, r1_as, r1_bc, r1_bs;
    logic [HW-1:0]         r1_h [4];      // ahx, ahy, bhx, bhy

    // stage 2: products
    logic                  r2_vld;
    logic signed [PDW-1:0] r2_pd [8];
    logic signed [PRW-1:0] r2_pr [4];
    logic [HW-1:0]         r2_h  [4];
    logic signed [PDW-1:0] n_pd  [8];
    logic signed [PRW-1:0] n_pr  [4];

    // stage 3: dot magnitudes
    logic                  r3_vld;
    logic [MAGW-1:0]       r3_dist [4];
    logic [CMW-1:0]        r3_mc, r3_ms;
    logic [HW-1:0]         r3_h    [4];
    logic [MAGW-1:0]       n_dist  [4];
    logic [CMW-1:0]        n_mc, n_ms;
    logic signed [DOTW-1:0] w_dot  [4];
    logic signed [CRW-1:0]  w_c, w_s;

    // stage 4: radius cross terms
    logic                  r4_vld;
    logic [MAGW-1:0]       r4_dist [4];
    logic [XW-1:0]         r4_x1   [4];
    logic [XW-1:0]         r4_x2   [4];
    logic [HW-1:0]         r4_own  [4];
    logic [XW-1:0]         n_x1    [4];
    logic [XW-1:0]         n_x2    [4];

    // stage 5: summed radii
    logic                  r5_vld;
    logic [MAGW-1:0]       r5_dist [4];
    logic [RW-1:0]         r5_rad  [4];
    logic [RW-1:0]         n_rad   [4];

    // stage 6: compare, first separating axis
    logic                           r6_vld;
    logic                           r6_overlap;
    logic [obb_pkg::AXIS_W-1:0]     r6_axis;
    logic                           n_overlap;
    logic [obb_pkg::AXIS_W-1:0]     n_axis;
    logic [3:0]                     w_sep;

    logic w_acc;

    assign o_busy = !r_run;
    assign w_acc  = i_start && !o_busy;

    // products: axis components are ax=(ac,as) ay=(-as,ac) bx=(bc,bs) by=(-bs,bc)
    always_comb begin
        n_pd[0] = PDW'(r1_dx) * PDW'(r1_ac);
        n_pd[1] = PDW'(r1_dy) * PDW'(r1_as);
        n_pd[2] = PDW'(r1_dx) * PDW'(r1_as);
        n_pd[3] = PDW'(r1_dy) * PDW'(r1_ac);
        n_pd[4] = PDW'(r1_dx) * PDW'(r1_bc);
        n_pd[5] = PDW'(r1_dy) * PDW'(r1_bs);
        n_pd[6] = PDW'(r1_dx) * PDW'(r1_bs);
        n_pd[7] = PDW'(r1_dy) * PDW'(r1_bc);
        n_pr[0] = PRW'(r1_ac) * PRW'(r1_bc);
        n_pr[1] = PRW'(r1_as) * PRW'(r1_bs);
        n_pr[2] = PRW'(r1_ac) * PRW'(r1_bs);
        n_pr[3] = PRW'(r1_as) * PRW'(r1_bc);
    end

    // dot products; every cross dot between the two frames is +-c or +-s
    always_comb begin
        w_dot[0] = DOTW'(r2_pd[0]) + DOTW'(r2_pd[1]);
        w_dot[1] = DOTW'(r2_pd[3]) - DOTW'(r2_pd[2]);
        w_dot[2] = DOTW'(r2_pd[4]) + DOTW'(r2_pd[5]);
        w_dot[3] = DOTW'(r2_pd[7]) - DOTW'(r2_pd[6]);
        w_c      = CRW'(r2_pr[0]) + CRW'(r2_pr[1]);
        w_s      = CRW'(r2_pr[2]) - CRW'(r2_pr[3]);
        for (int k = 0; k < 4; k++) begin
            n_dist[k] = w_dot[k][DOTW-1] ? MAGW'(-w_dot[k]) : MAGW'(w_dot[k]);
        end
        n_mc = w_c[CRW-1] ? CMW'(-w_c) : CMW'(w_c);
        n_ms = w_s[CRW-1] ? CMW'(-w_s) : CMW'(w_s);
    end

    // other box's projected radius; half index 0 ahx, 1 ahy, 2 bhx, 3 bhy
    always_comb begin
        n_x1[0] = XW'(r3_mc) * XW'(r3_h[2]);
        n_x2[0] = XW'(r3_ms) * XW'(r3_h[3]);
        n_x1[1] = XW'(r3_ms) * XW'(r3_h[2]);
        n_x2[1] = XW'(r3_mc) * XW'(r3_h[3]);
        n_x1[2] = XW'(r3_mc) * XW'(r3_h[0]);
        n_x2[2] = XW'(r3_ms) * XW'(r3_h[1]);
        n_x1[3] = XW'(r3_ms) * XW'(r3_h[0]);
        n_x2[3] = XW'(r3_mc) * XW'(r3_h[1]);
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            n_rad[k] = RW'({r4_own[k], {OSH{1'b0}}}) + RW'(r4_x1[k]) + RW'(r4_x2[k]);
        end
    end

    // touching does not separate; lowest axis wins
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_sep[k] = RW'({r5_dist[k], {DSH{1'b0}}}) > r5_rad[k];
        end
        n_overlap = 1'b0;
        if (w_sep[0]) begin
            n_axis = obb_pkg::AXIS_AX;
        end else if (w_sep[1]) begin
            n_axis = obb_pkg::AXIS_AY;
        end else if (w_sep[2]) begin
            n_axis = obb_pkg::AXIS_BX;
        end else if (w_sep[3]) begin
            n_axis = obb_pkg::AXIS_BY;
        end else begin
            n_axis    = obb_pkg::AXIS_NONE;
            n_overlap = 1'b1;
        end
    end

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
            r6_vld <= 1'b0;
        end else begin
            r_run  <= 1'b1;
            r1_vld <= w_acc;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
            r5_vld <= r4_vld;
            r6_vld <= r5_vld;
        end
    end

    // data path, no reset
    always_ff @(posedge i_clk) begin
        r1_dx   <= DW'(i_item.a_center_x) - DW'(i_item.b_center_x);
        r1_dy   <= DW'(i_item.a_center_y) - DW'(i_item.b_center_y);
        r1_ac   <= i_item.a_cos;
        r1_as   <= i_item.a_sin;
        r1_bc   <= i_item.b_cos;
        r1_bs   <= i_item.b_sin;
        r1_h[0] <= i_item.a_half_x;
        r1_h[1] <= i_item.a_half_y;
        r1_h[2] <= i_item.b_half_x;
        r1_h[3] <= i_item.b_half_y;

        r2_pd <= n_pd;
        r2_pr <= n_pr;
        r2_h  <= r1_h;

        r3_dist <= n_dist;
        r3_mc   <= n_mc;
        r3_ms   <= n_ms;
        r3_h    <= r2_h;

        r4_dist <= r3_dist;
        r4_x1   <= n_x1;
        r4_x2   <= n_x2;
        r4_own  <= r3_h;

        r5_dist <= r4_dist;
        r5_rad  <= n_rad;

        r6_overlap <= n_overlap;
        r6_axis    <= n_axis;
    end

    assign o_done                   = r6_vld;
    assign o_result.overlap         = r6_overlap;
    assign o_result.separating_axis = r6_axis;

endmodule
`default_nettype wire

/* design/obb_checker.sv */
// Checker on the top level's ports of the OBB overlap test, and its bind.
`default_nettype none
`include "obb_overlap_test_2d_top_defines.svh"
module obb_checker (
    input wire                    i_clk,
    input wire                    i_rst_n,
    input wire                    i_start,
    input wire                    o_busy,
    input wire                    o_done,
    input wire obb_pkg::t_obb_out o_result
);

    logic w_acc;
    logic w_none;

    assign w_acc  = i_start && !o_busy;
    assign w_none = o_result.separating_axis == obb_pkg::AXIS_NONE;

    `OBB_ASSERT_NEXT(a_reset_flush, i_clk, !i_rst_n, !o_done && o_busy)
    `OBB_ASSERT_DELAY(a_latency, i_clk, i_rst_n, w_acc, obb_pkg::PIPE_DEPTH, o_done)
    `OBB_ASSERT_IMPLY(a_flag_axis, i_clk, i_rst_n, o_done, o_result.overlap == w_none)
    `OBB_ASSERT_IMPLY(a_axis_code, i_clk, i_rst_n, o_done, o_result.separating_axis <= obb_pkg::AXIS_NONE)

endmodule

bind obb_overlap_test_2d_top obb_checker u_obb_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_start  (i_start),
    .o_busy   (o_busy),
    .o_done   (o_done),
    .o_result (o_result)
);
`default_nettype wire
